// ===== sv/nru_cs_pkg.sv =====
// Package for the NRU cache set: controller states, command bundle, constants.
// Used by nru_cs_ctrl, nru_cs_dp and nru_cache_set; depends on nothing.
`default_nettype none
package nru_cs_pkg;

  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned WAY_IDX_W    = 3;
  localparam int unsigned NUM_CLASSES  = 4;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 16'd16;
  localparam logic [APB_ADDR_W-1:0] REG_PERIOD   = 3'd0;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic execute;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== sv/nru_cache_set.sv =====
// Top level of the NRU cache set: joins the controller and the datapath.
// Depends on nru_cs_pkg, nru_cs_ctrl and nru_cs_dp.
//
// Usage:
//   One fully associative set of NUM_WAYS ways with not-recently-used
//   replacement. An item (operation, lookup_tag, access_data) enters on the
//   in_ channel by valid/ready; one result item per access leaves on the
//   out_ channel by valid/ready, in order.
//   The item is captured in the input register; the parallel tag compare,
//   victim pick and way update then load the output register and raise out_valid
//   once the output slot is free. No new item is taken until then.
//   A new item is taken while an earlier result still waits in the output
//   register. If the receiver stalls, that register holds its item and the
//   next item waits in the input register until the output slot frees.
//   The period register sits at APB address 0; write it only while idle.
//   Reset (rst_n low, synchronous) empties both channels, invalidates all
//   ways, clears all marks and the access counter, and sets the period to 16.
`default_nettype none
module nru_cache_set #(
  parameter int unsigned NUM_WAYS   = 8,
  parameter int unsigned TAG_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_operation,
  input  wire  [TAG_BITS-1:0]                  in_lookup_tag,
  input  wire  [VALUE_BITS-1:0]                in_access_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_hit,
  output logic [nru_cs_pkg::WAY_IDX_W-1:0]     out_way_index,
  output logic [VALUE_BITS-1:0]                out_read_data,
  output logic                                 out_evicted,
  output logic                                 out_evicted_dirty,
  output logic [TAG_BITS-1:0]                  out_evicted_tag,
  output logic [VALUE_BITS-1:0]                out_evicted_data,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [nru_cs_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [nru_cs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nru_cs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                 pready
);

  nru_cs_pkg::dp_cmd_t cmd;

  assign pready = 1'b1;

  nru_cs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  nru_cs_dp #(
    .NUM_WAYS   (NUM_WAYS),
    .TAG_BITS   (TAG_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_lookup_tag     (in_lookup_tag),
    .in_access_data    (in_access_data),
    .out_hit           (out_hit),
    .out_way_index     (out_way_index),
    .out_read_data     (out_read_data),
    .out_evicted       (out_evicted),
    .out_evicted_dirty (out_evicted_dirty),
    .out_evicted_tag   (out_evicted_tag),
    .out_evicted_data  (out_evicted_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata)
  );

endmodule
`default_nettype wire

// ===== sv/nru_cs_ctrl.sv =====
// Controller of the NRU cache set: input/output handshake and sequencing.
// Depends on nru_cs_pkg; drives the command bundle of nru_cs_dp.
`default_nettype none
module nru_cs_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output nru_cs_pkg::dp_cmd_t   cmd
);

  nru_cs_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nru_cs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = nru_cs_pkg::ST_EVAL;
      end
      nru_cs_pkg::ST_EVAL: begin
        if (slot_free) state_nxt = nru_cs_pkg::ST_IDLE;
      end
      default: state_nxt = nru_cs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.execute   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      nru_cs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      nru_cs_pkg::ST_EVAL: begin
        cmd.execute = slot_free;
        if (slot_free) out_valid_nxt = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nru_cs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== sv/nru_cs_dp.sv =====
// Datapath of the NRU cache set: way state, tag match, victim pick, result register.
// Depends on nru_cs_pkg; sequenced by nru_cs_ctrl through the command bundle.
`default_nettype none
module nru_cs_dp #(
  parameter int unsigned NUM_WAYS   = 8,
  parameter int unsigned TAG_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  nru_cs_pkg::dp_cmd_t                  cmd,
  input  wire                                  in_operation,
  input  wire  [TAG_BITS-1:0]                  in_lookup_tag,
  input  wire  [VALUE_BITS-1:0]                in_access_data,
  output logic                                 out_hit,
  output logic [nru_cs_pkg::WAY_IDX_W-1:0]     out_way_index,
  output logic [VALUE_BITS-1:0]                out_read_data,
  output logic                                 out_evicted,
  output logic                                 out_evicted_dirty,
  output logic [TAG_BITS-1:0]                  out_evicted_tag,
  output logic [VALUE_BITS-1:0]                out_evicted_data,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [nru_cs_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [nru_cs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nru_cs_pkg::APB_DATA_W-1:0]    prdata
);

  localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  logic                          op_r;
  logic [TAG_BITS-1:0]           tag_r;
  logic [VALUE_BITS-1:0]         data_r;

  logic [NUM_WAYS-1:0]           valid_r, valid_nxt;
  logic [NUM_WAYS-1:0]           ref_r, ref_nxt;
  logic [NUM_WAYS-1:0]           mod_r, mod_nxt;
  logic [TAG_BITS-1:0]           tags_r   [NUM_WAYS];
  logic [VALUE_BITS-1:0]         values_r [NUM_WAYS];
  logic [nru_cs_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [nru_cs_pkg::PERIOD_W-1:0] period_r;

  logic                          hit;
  logic [WAY_W-1:0]              hit_way;
  logic                          found_inv;
  logic [WAY_W-1:0]              inv_way;
  logic                          found_cls;
  logic [WAY_W-1:0]              cls_way;
  logic [WAY_W-1:0]              sel_way;
  logic                          evict;
  logic                          expire;
  logic [nru_cs_pkg::COUNT_W-1:0]  count_inc;
  logic [VALUE_BITS-1:0]         result_data;
  logic [WAY_W+2:0]              way_wide;
  logic                          is_write;
  logic                          cfg_write;

  assign is_write = (op_r == nru_cs_pkg::OP_WRITE);

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && valid_r[w] && (tags_r[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    found_inv = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found_inv && !valid_r[w]) begin
        found_inv = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    found_cls = 1'b0;
    cls_way   = '0;
    for (int c = 0; c < nru_cs_pkg::NUM_CLASSES; c++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!found_cls && ({ref_r[w], mod_r[w]} == 2'(c))) begin
          found_cls = 1'b1;
          cls_way   = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    if (hit) begin
      sel_way = hit_way;
    end else if (found_inv) begin
      sel_way = inv_way;
    end else begin
      sel_way = cls_way;
    end
  end

  assign evict     = !hit && valid_r[sel_way];
  assign count_inc = count_r + 1'b1;
  assign expire    = count_inc > {1'b0, period_r};
  assign count_nxt = expire ? '0 : count_inc;
  assign way_wide  = (WAY_W + 3)'(sel_way);

  always_comb begin
    if (hit && !is_write) begin
      result_data = values_r[sel_way];
    end else begin
      result_data = data_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    ref_nxt   = expire ? '0 : ref_r;
    mod_nxt   = mod_r;
    if (hit) begin
      if (is_write) begin
        mod_nxt[sel_way] = 1'b1;
      end else begin
        ref_nxt[sel_way] = 1'b1;
      end
    end else begin
      valid_nxt[sel_way] = 1'b1;
      ref_nxt[sel_way]   = 1'b1;
      mod_nxt[sel_way]   = is_write;
    end
  end

  assign cfg_write = psel && penable && pwrite && (paddr == nru_cs_pkg::REG_PERIOD);

  always_comb begin
    if (paddr == nru_cs_pkg::REG_PERIOD) begin
      prdata = nru_cs_pkg::APB_DATA_W'(period_r);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ref_r    <= '0;
      mod_r    <= '0;
      count_r  <= '0;
      period_r <= nru_cs_pkg::PERIOD_RESET;
    end else begin
      if (cfg_write) period_r <= pwdata[nru_cs_pkg::PERIOD_W-1:0];
      if (cmd.execute) begin
        valid_r <= valid_nxt;
        ref_r   <= ref_nxt;
        mod_r   <= mod_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      tag_r  <= in_lookup_tag;
      data_r <= in_access_data;
    end
    if (cmd.execute) begin
      if (!hit || is_write) begin
        values_r[sel_way] <= data_r;
      end
      if (!hit) begin
        tags_r[sel_way] <= tag_r;
      end
      out_hit           <= hit;
      out_way_index     <= way_wide[nru_cs_pkg::WAY_IDX_W-1:0];
      out_read_data     <= result_data;
      out_evicted       <= evict;
      out_evicted_dirty <= evict && mod_r[sel_way];
      out_evicted_tag   <= evict ? tags_r[sel_way] : '0;
      out_evicted_data  <= evict ? values_r[sel_way] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== bench/nru_cache_set_tb.sv =====
// Testbench for nru_cache_set: random and directed accesses, predicted per item
// and checked field by field. Depends on nru_cs_pkg and nru_cache_set.
`timescale 1ns / 100ps

module nru_cache_set_tb;

  localparam int unsigned NUM_WAYS    = 8;
  localparam int unsigned TAG_BITS    = 32;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_PRINTS  = 30;

  typedef struct packed {
    nru_cs_pkg::op_t       op;
    logic [TAG_BITS-1:0]   tag;
    logic [VALUE_BITS-1:0] data;
  } access_t;

  typedef struct packed {
    logic                              hit;
    logic [nru_cs_pkg::WAY_IDX_W-1:0]  way;
    logic [VALUE_BITS-1:0]             read_data;
    logic                              evicted;
    logic                              evicted_dirty;
    logic [TAG_BITS-1:0]               evicted_tag;
    logic [VALUE_BITS-1:0]             evicted_data;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_operation = 1'b0;
  logic [TAG_BITS-1:0]                in_lookup_tag = '0;
  logic [VALUE_BITS-1:0]              in_access_data = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               out_hit;
  logic [nru_cs_pkg::WAY_IDX_W-1:0]   out_way_index;
  logic [VALUE_BITS-1:0]              out_read_data;
  logic                               out_evicted;
  logic                               out_evicted_dirty;
  logic [TAG_BITS-1:0]                out_evicted_tag;
  logic [VALUE_BITS-1:0]              out_evicted_data;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [nru_cs_pkg::APB_ADDR_W-1:0]  paddr = '0;
  logic [nru_cs_pkg::APB_DATA_W-1:0]  pwdata = '0;
  logic [nru_cs_pkg::APB_DATA_W-1:0]  prdata;
  logic                               pready;

  nru_cache_set #(
    .NUM_WAYS   (NUM_WAYS),
    .TAG_BITS   (TAG_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_lookup_tag     (in_lookup_tag),
    .in_access_data    (in_access_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_way_index     (out_way_index),
    .out_read_data     (out_read_data),
    .out_evicted       (out_evicted),
    .out_evicted_dirty (out_evicted_dirty),
    .out_evicted_tag   (out_evicted_tag),
    .out_evicted_data  (out_evicted_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted contents of the set
  logic [NUM_WAYS-1:0]              line_valid = '0;
  logic [NUM_WAYS-1:0]              line_ref   = '0;
  logic [NUM_WAYS-1:0]              line_mod   = '0;
  logic [TAG_BITS-1:0]              line_tag   [NUM_WAYS];
  logic [VALUE_BITS-1:0]            line_value [NUM_WAYS];
  logic [nru_cs_pkg::COUNT_W-1:0]   access_count = '0;
  logic [nru_cs_pkg::PERIOD_W-1:0]  flag_period  = nru_cs_pkg::PERIOD_RESET;

  access_t  pending_accesses  [$];
  outcome_t expected_outcomes [$];

  int unsigned error_count = 0;
  int unsigned in_accepts  = 0;
  int unsigned out_accepts = 0;
  int unsigned stall_cycles = 0;
  logic        hold_req = 1'b0;

  initial begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      line_tag[w]   = '0;
      line_value[w] = '0;
    end
  end

  function automatic outcome_t cache_access(input access_t acc);
    outcome_t    res;
    logic        found;
    logic        picked;
    int unsigned way;
    res    = '0;
    found  = 1'b0;
    picked = 1'b0;
    way    = 0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (!found && line_valid[w] && line_tag[w] == acc.tag) begin
        found = 1'b1;
        way   = w;
      end
    if (!found) begin
      for (int w = 0; w < NUM_WAYS; w++)
        if (!picked && !line_valid[w]) begin
          picked = 1'b1;
          way    = w;
        end
      for (int cls = 0; cls < nru_cs_pkg::NUM_CLASSES; cls++)
        for (int w = 0; w < NUM_WAYS; w++)
          if (!picked && {line_ref[w], line_mod[w]} == 2'(cls)) begin
            picked = 1'b1;
            way    = w;
          end
      if (line_valid[way]) begin
        res.evicted       = 1'b1;
        res.evicted_dirty = line_mod[way];
        res.evicted_tag   = line_tag[way];
        res.evicted_data  = line_value[way];
      end
    end
    // period expiry clears referenced marks before this access's own update
    access_count = access_count + 1'b1;
    if (access_count > {1'b0, flag_period}) begin
      line_ref     = '0;
      access_count = '0;
    end
    if (found) begin
      if (acc.op == nru_cs_pkg::OP_WRITE) begin
        line_mod[way]   = 1'b1;
        line_value[way] = acc.data;
      end else begin
        line_ref[way] = 1'b1;
      end
    end else begin
      line_valid[way] = 1'b1;
      line_ref[way]   = 1'b1;
      line_mod[way]   = (acc.op == nru_cs_pkg::OP_WRITE);
      line_tag[way]   = acc.tag;
      line_value[way] = acc.data;
    end
    res.hit       = found;
    res.way       = way[nru_cs_pkg::WAY_IDX_W-1:0];
    res.read_data = line_value[way];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // input side: hold until accepted, then wait a drawn gap
  always @(negedge clk) begin : drive_in
    logic        taken;
    access_t     nxt;
    int unsigned in_seen;
    int unsigned tx_gap;
    logic        tx_burst;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_seen  = 0;
      tx_gap   = 0;
      tx_burst = 1'b0;
    end else begin
      taken = (in_accepts != in_seen);
      if (taken) begin
        in_seen = in_accepts;
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 13);
      end
      if (!in_valid || taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          nxt = pending_accesses.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= nxt.op;
          in_lookup_tag  <= nxt.tag;
          in_access_data <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: wait a drawn number of cycles per item, or a long hold
  always @(negedge clk) begin : drive_out
    int unsigned out_seen;
    int unsigned rx_wait;
    int unsigned hold_cnt;
    logic        rx_burst;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_seen = 0;
      rx_wait  = 0;
      hold_cnt = 0;
      rx_burst = 1'b0;
    end else begin
      if (out_accepts != out_seen) begin
        out_seen = out_accepts;
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_accepts++;
        got = '{out_hit, out_way_index, out_read_data, out_evicted,
                out_evicted_dirty, out_evicted_tag, out_evicted_data};
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected item, read_data", got.read_data, '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.way !== want.way)
            report_mismatch("way_index", 32'(got.way), 32'(want.way));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.evicted !== want.evicted)
            report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
          if (got.evicted_dirty !== want.evicted_dirty)
            report_mismatch("evicted_dirty", 32'(got.evicted_dirty),
                            32'(want.evicted_dirty));
          if (got.evicted_tag !== want.evicted_tag)
            report_mismatch("evicted_tag", got.evicted_tag, want.evicted_tag);
          if (got.evicted_data !== want.evicted_data)
            report_mismatch("evicted_data", got.evicted_data, want.evicted_data);
        end
      end
      if (in_valid && in_ready) begin
        in_accepts++;
        expected_outcomes.push_back(cache_access(
          '{nru_cs_pkg::op_t'(in_operation), in_lookup_tag, in_access_data}));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("nru_cache_set_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [nru_cs_pkg::APB_ADDR_W-1:0] addr,
                           input logic [nru_cs_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input logic [nru_cs_pkg::APB_ADDR_W-1:0] addr,
                          output logic [nru_cs_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_flag_period();
    logic [nru_cs_pkg::APB_DATA_W-1:0] rd;
    cfg_read(nru_cs_pkg::REG_PERIOD, rd);
    if (rd !== {{(nru_cs_pkg::APB_DATA_W-nru_cs_pkg::PERIOD_W){1'b0}}, flag_period})
      report_mismatch("flag_reset_period readback", rd, 32'(flag_period));
  endtask

  task automatic set_flag_period(input logic [nru_cs_pkg::PERIOD_W-1:0] value);
    cfg_write(nru_cs_pkg::REG_PERIOD,
              {{(nru_cs_pkg::APB_DATA_W-nru_cs_pkg::PERIOD_W){1'b0}}, value});
    flag_period = value;
    check_flag_period();
  endtask

  task automatic queue_access(input nru_cs_pkg::op_t op, input logic [TAG_BITS-1:0] tag,
                              input logic [VALUE_BITS-1:0] data);
    pending_accesses.push_back('{op, tag, data});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_accesses.size() != 0 || in_valid || expected_outcomes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly a small tag pool so hits and evictions dominate, some fresh tags
  task automatic run_random(input int count, input int pool_size, input logic hold_off);
    logic [TAG_BITS-1:0] pool [$];
    access_t             acc;
    @(posedge clk);
    repeat (pool_size) pool.push_back($urandom);
    repeat (count) begin
      acc.op   = $urandom_range(0, 1) ? nru_cs_pkg::OP_WRITE : nru_cs_pkg::OP_READ;
      acc.tag  = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
      acc.data = $urandom;
      pending_accesses.push_back(acc);
    end
    if (hold_off) hold_req = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_flag_period();

    queue_access(nru_cs_pkg::OP_READ,  32'h0000_0000, 32'h0000_0000);
    queue_access(nru_cs_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_access(nru_cs_pkg::OP_READ,  32'h0000_0001, 32'h8000_0000);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h8000_0000, 32'h0000_0001);
    queue_access(nru_cs_pkg::OP_READ,  32'h1234_5678, 32'hDEAD_BEEF);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h8765_4321, 32'hCAFE_F00D);
    queue_access(nru_cs_pkg::OP_READ,  32'h0F0F_0F0F, 32'hA5A5_A5A5);
    queue_access(nru_cs_pkg::OP_WRITE, 32'hF0F0_F0F0, 32'h5A5A_5A5A);
    queue_access(nru_cs_pkg::OP_READ,  32'hFFFF_FFFF, 32'h1111_1111);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h0000_0001, 32'h0000_0000);
    queue_access(nru_cs_pkg::OP_READ,  32'h8000_0000, 32'h2222_2222);
    queue_access(nru_cs_pkg::OP_READ,  32'hAAAA_AAAA, 32'h1357_2468);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h5555_5555, 32'h8642_9753);
    queue_access(nru_cs_pkg::OP_READ,  32'h1212_1212, 32'h3333_3333);
    queue_access(nru_cs_pkg::OP_READ,  32'h3434_3434, 32'h4444_4444);
    queue_access(nru_cs_pkg::OP_READ,  32'h5656_5656, 32'h5555_5555);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h7878_7878, 32'h6666_6666);
    queue_access(nru_cs_pkg::OP_WRITE, 32'h9A9A_9A9A, 32'h7777_7777);
    queue_access(nru_cs_pkg::OP_READ,  32'hFFFF_FFFF, 32'h8888_8888);
    queue_access(nru_cs_pkg::OP_READ,  32'h0000_0000, 32'h9999_9999);
    queue_access(nru_cs_pkg::OP_WRITE, 32'hBCBC_BCBC, 32'hAAAA_AAAA);
    wait_drained();

    set_flag_period(16'd0);
    run_random(200, 9, 1'b0);
    set_flag_period(16'hFFFF);
    run_random(250, 12, 1'b1);
    set_flag_period(16'd3);
    run_random(250, 16, 1'b0);
    set_flag_period(16'($urandom_range(4, 40)));
    run_random(200, 10, 1'b0);
    set_flag_period(16'($urandom));
    run_random(200, 11, 1'b0);

    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("nru_cache_set_tb OK");
    end else begin
      $display("nru_cache_set_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nru_cs_pkg.sv
sv/nru_cs_ctrl.sv
sv/nru_cs_dp.sv
sv/nru_cache_set.sv
bench/nru_cache_set_tb.sv
